// ----- design/ltesg_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LT encoding symbol generator package
// Shared constants, types and helpers for the symbol store, the remainder
// unit and the encode sequencer.
// ----------------------------------------------------------------------------
package ltesg_pkg;

  // The store depth is a power of two, so address wrapping is a mask.
  localparam int SYMBOL_DEPTH = 4096;
  localparam int ADDR_W       = $clog2(SYMBOL_DEPTH);

  localparam int SYM_W   = 8;
  localparam int IDX_W   = 12;
  localparam int VAL_W   = 13;
  localparam int SUM_W   = VAL_W + 1;
  localparam int DEG_W   = 5;
  localparam int PDEG_W  = 2;
  localparam int CIDX_W  = 2;

  localparam int          SKIP_W     = 14;
  localparam logic [13:0] SKIP_LIMIT = 14'd8192;

  localparam int REM_LANES = 4;
  localparam int REM_CNT_W = $clog2(VAL_W);
  localparam int LANE_A    = 0;
  localparam int LANE_B    = 1;
  localparam int LANE_A1   = 2;
  localparam int LANE_B1   = 3;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_ENCODE = 1'b1;

  localparam logic [CIDX_W-1:0] REG_LT_COUNT       = 2'd0;
  localparam logic [CIDX_W-1:0] REG_INACTIVE_COUNT = 2'd1;
  localparam logic [CIDX_W-1:0] REG_INACTIVE_PRIME = 2'd2;

  typedef logic [VAL_W-1:0] val_t;
  typedef val_t [REM_LANES-1:0] lanes_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_LT,
    ST_PI,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] addr;
    logic [SYM_W-1:0]  wdata;
  } store_req_t;

  function automatic logic [ADDR_W-1:0] store_addr(input logic [SUM_W-1:0] v);
    logic [31:0] wide;
    wide = 32'(v) % 32'(SYMBOL_DEPTH);
    return wide[ADDR_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- design/ltesg_store.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Intermediate symbol store
// Single-port synchronous memory of byte symbols with a registered read.
// ----------------------------------------------------------------------------
module ltesg_store
  import ltesg_pkg::*;
(
  input  wire logic             clk,
  input  wire store_req_t       req,
  output logic      [SYM_W-1:0] rdata
);

  logic [SYM_W-1:0] mem [SYMBOL_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd_en) begin
      rdata <= mem[req.addr];
    end
  end

endmodule
`default_nettype wire

// ----- design/ltesg_rem.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Remainder unit
// Four restoring remainder lanes that retire one operand bit per cycle and
// hold their results until the next start.
// ----------------------------------------------------------------------------
module ltesg_rem
  import ltesg_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   start,
  input  wire lanes_t operands,
  input  wire lanes_t moduli,
  output logic        done,
  output lanes_t      rems
);

  lanes_t               xs;
  lanes_t               ms;
  lanes_t               rems_next;
  logic                 run;
  logic [REM_CNT_W-1:0] cnt;

  always_comb begin
    logic [SUM_W-1:0] t;
    rems_next = rems;
    for (int i = 0; i < REM_LANES; i++) begin
      t = {rems[i], xs[i][VAL_W-1]};
      if (t >= {1'b0, ms[i]}) begin
        t = t - {1'b0, ms[i]};
      end
      rems_next[i] = t[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == REM_CNT_W'(VAL_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xs   <= operands;
      ms   <= moduli;
      rems <= '0;
    end else if (run) begin
      rems <= rems_next;
      for (int i = 0; i < REM_LANES; i++) begin
        xs[i] <= {xs[i][VAL_W-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

// ----- design/lt_encoding_symbol_generator_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LT encoding symbol generator
// Loads byte symbols into a store and, for an encode command carrying a
// precomputed tuple, returns the XOR of the selected LT and inactivated
// symbols.
//
//   Channel   Signals                                     Direction
//   command   start, busy, opcode, load_*, tuple fields   in (busy out)
//   result    done, encoding_symbol                       out
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data   in (ready out)
//
// A load leaves busy low. An encode keeps busy high through the bit-serial
// reduction of the strides and start indices, then one store read per cycle
// on the single memory port, except while skipped inactivated candidates
// are searched. The result is shown with done for one cycle, in the cycle
// in which busy falls.
// Reset is synchronous; it restores W, P and P1 to one but leaves the store.
// ----------------------------------------------------------------------------
module lt_encoding_symbol_generator_top
  import ltesg_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              opcode,
  input  wire logic [IDX_W-1:0]  load_index,
  input  wire logic [SYM_W-1:0]  load_value,
  input  wire logic [DEG_W-1:0]  degree,
  input  wire logic [IDX_W-1:0]  lt_step,
  input  wire logic [IDX_W-1:0]  start_index,
  input  wire logic [PDEG_W-1:0] pi_degree,
  input  wire logic [VAL_W-1:0]  pi_step,
  input  wire logic [VAL_W-1:0]  pi_start,
  output logic                   done,
  output logic      [SYM_W-1:0]  encoding_symbol,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CIDX_W-1:0] cfg_index,
  input  wire logic [VAL_W-1:0]  cfg_data
);

  state_t state;
  state_t state_next;

  logic [IDX_W-1:0] w_cfg;
  logic [IDX_W-1:0] p_cfg;
  logic [VAL_W-1:0] p1_cfg;
  logic [IDX_W-1:0] w_eff;
  logic [VAL_W-1:0] p1_eff;

  logic              accept;
  logic              rem_start;
  logic              rem_done;
  lanes_t            rem_ops;
  lanes_t            rem_mods;
  lanes_t            rems;
  store_req_t        store_req;
  logic [SYM_W-1:0]  rdata;
  logic              rd_pend;
  logic [SYM_W-1:0]  acc;

  logic [IDX_W-1:0]  b_cur;
  logic [DEG_W-1:0]  lt_left;
  logic [PDEG_W-1:0] pi_left;
  logic [VAL_W-1:0]  pi_cur;
  logic              pi_raw;
  logic [SKIP_W-1:0] skip_n;

  logic [IDX_W:0]    lt_sum;
  logic [IDX_W-1:0]  lt_next;
  logic [VAL_W-1:0]  pi_base;
  logic [SUM_W-1:0]  pi_sum;
  logic [VAL_W-1:0]  pi_next;
  logic              search_more;
  logic [SUM_W-1:0]  pi_addr;

  assign w_eff  = (w_cfg == '0) ? IDX_W'(1) : w_cfg;
  assign p1_eff = (p1_cfg == '0) ? VAL_W'(1) : p1_cfg;

  assign accept    = start && !busy;
  assign busy      = (state != ST_IDLE);
  assign cfg_ready = (state == ST_IDLE) && !start;

  always_ff @(posedge clk) begin
    if (rst) begin
      w_cfg  <= IDX_W'(1);
      p_cfg  <= IDX_W'(1);
      p1_cfg <= VAL_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LT_COUNT:       w_cfg  <= cfg_data[IDX_W-1:0];
        REG_INACTIVE_COUNT: p_cfg  <= cfg_data[IDX_W-1:0];
        REG_INACTIVE_PRIME: p1_cfg <= cfg_data;
        default:            ;
      endcase
    end
  end

  always_comb begin
    rem_ops           = '0;
    rem_ops[LANE_A]   = {1'b0, lt_step};
    rem_ops[LANE_B]   = {1'b0, start_index};
    rem_ops[LANE_A1]  = pi_step;
    rem_ops[LANE_B1]  = pi_start;
    rem_mods          = '0;
    rem_mods[LANE_A]  = {1'b0, w_eff};
    rem_mods[LANE_B]  = {1'b0, w_eff};
    rem_mods[LANE_A1] = p1_eff;
    rem_mods[LANE_B1] = p1_eff;
  end

  ltesg_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .operands (rem_ops),
    .moduli   (rem_mods),
    .done     (rem_done),
    .rems     (rems)
  );

  ltesg_store u_store (
    .clk   (clk),
    .req   (store_req),
    .rdata (rdata)
  );

  // LT stride: both terms are already below W, so one subtraction reduces.
  assign lt_sum  = {1'b0, b_cur} + {1'b0, rems[LANE_A][IDX_W-1:0]};
  assign lt_next = (lt_sum >= {1'b0, w_eff}) ? IDX_W'(lt_sum - {1'b0, w_eff})
                                              : lt_sum[IDX_W-1:0];

  // The first inactivated step starts from the reduced form of the raw start.
  assign pi_base     = pi_raw ? rems[LANE_B1] : pi_cur;
  assign pi_sum      = {1'b0, pi_base} + {1'b0, rems[LANE_A1]};
  assign pi_next     = (pi_sum >= {1'b0, p1_eff}) ? VAL_W'(pi_sum - {1'b0, p1_eff})
                                                  : pi_sum[VAL_W-1:0];
  assign search_more = (pi_cur >= {1'b0, p_cfg}) && (skip_n != SKIP_LIMIT);
  assign pi_addr     = {2'b00, w_eff} + {1'b0, pi_cur};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    rem_start       = 1'b0;
    store_req       = '0;
    store_req.wdata = load_value;
    case (state)
      ST_IDLE: begin
        if (accept && opcode == OP_LOAD) begin
          store_req.wr_en = 1'b1;
          store_req.addr  = store_addr(SUM_W'(load_index));
        end else if (accept) begin
          store_req.rd_en = 1'b1;
          store_req.addr  = store_addr(SUM_W'(start_index));
          rem_start       = 1'b1;
          state_next      = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (rem_done) begin
          state_next = (lt_left == '0) ? ST_PI : ST_LT;
        end
      end
      ST_LT: begin
        store_req.rd_en = 1'b1;
        store_req.addr  = store_addr(SUM_W'(lt_next));
        if (lt_left == DEG_W'(1)) begin
          state_next = ST_PI;
        end
      end
      ST_PI: begin
        if (!search_more) begin
          store_req.rd_en = 1'b1;
          store_req.addr  = store_addr(pi_addr);
          if (pi_left == '0) begin
            state_next = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
      done    <= 1'b0;
    end else begin
      rd_pend <= store_req.rd_en;
      done    <= (state == ST_DRAIN);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept) begin
      acc     <= '0;
      lt_left <= (degree == '0) ? '0 : DEG_W'(degree - 1'b1);
      pi_left <= (pi_degree == '0) ? '0 : PDEG_W'(pi_degree - 1'b1);
      pi_cur  <= pi_start;
      pi_raw  <= 1'b1;
      skip_n  <= '0;
    end else begin
      if (rd_pend) begin
        acc <= acc ^ rdata;
      end
      case (state)
        ST_REDUCE: begin
          b_cur <= rems[LANE_B][IDX_W-1:0];
        end
        ST_LT: begin
          b_cur   <= lt_next;
          lt_left <= lt_left - 1'b1;
        end
        ST_PI: begin
          if (search_more) begin
            pi_cur <= pi_next;
            pi_raw <= 1'b0;
            skip_n <= skip_n + 1'b1;
          end else if (pi_left != '0) begin
            pi_cur  <= pi_next;
            pi_raw  <= 1'b0;
            skip_n  <= '0;
            pi_left <= pi_left - 1'b1;
          end
        end
        ST_DRAIN: begin
          encoding_symbol <= acc ^ rdata;
        end
        default: ;
      endcase
    end
  end

  a_done_after_drain: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == ST_DRAIN)
    else $error("Result strobe without a completed encode.");

  a_rem_in_reduce: assert property (@(posedge clk) disable iff (rst)
    rem_done |-> state == ST_REDUCE)
    else $error("Remainder unit finished outside the reduction phase.");

  a_lt_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LT) |-> (lt_next < w_eff))
    else $error("LT index left the range below W.");

  a_skip_bound: assert property (@(posedge clk) disable iff (rst)
    skip_n <= SKIP_LIMIT)
    else $error("Skip search ran past its limit.");

  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !store_req.wr_en)
    else $error("Store written during an encode.");

endmodule
`default_nettype wire
